[rtl/b62_pkg.sv]
// Shared types, constants and helpers for the base-62 digit converter.
`timescale 1ns / 1ps

package b62_pkg;

  // Item widths
  localparam int unsigned NUM_W    = 64;
  localparam int unsigned SYM_W    = 7;
  localparam int unsigned OUT_TD_W = 8;

  // Digit chain geometry: one cell per base-62 digit, one input chunk per cycle
  localparam int unsigned RADIX      = 62;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned CELL_N     = 11;
  localparam int unsigned CELL_IDX_W = 4;
  localparam int unsigned CHUNK_W    = 8;
  localparam int unsigned CHUNK_N    = NUM_W / CHUNK_W;

  // Cycles from the first chunk entering cell 0 to the last cell finishing
  localparam int unsigned CONV_CYCLES = CHUNK_N + CELL_N - 1;
  localparam int unsigned CNT_W       = 5;

  // Partial value inside a cell: digit * 2^CHUNK_W + carry, below 62 * 2^CHUNK_W
  localparam int unsigned ACC_W = DIGIT_W + CHUNK_W;

  // Reciprocal of 62 for the in-cell quotient: exact for every ACC_W-bit value
  localparam int unsigned RECIP_S = 20;
  localparam int unsigned RECIP_K = 16913;
  localparam int unsigned RECIP_W = 15;
  localparam int unsigned PROD_W  = ACC_W + RECIP_W;

  // Digit thresholds and ASCII offsets of the three alphabet ranges
  localparam int unsigned DIGIT_UPPER_LO = 10;
  localparam int unsigned DIGIT_LOWER_LO = 36;
  localparam int unsigned ASCII_DIGIT_OFS = 48;
  localparam int unsigned ASCII_UPPER_OFS = 55;
  localparam int unsigned ASCII_LOWER_OFS = 61;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_LEAD,
    ST_EMIT
  } b62_state_e;

  // Link handed from one cell to its more significant neighbor
  typedef struct packed {
    logic               en;
    logic [CHUNK_W-1:0] carry;
  } b62_link_t;

  // Map one digit value to its ASCII character
  function automatic logic [SYM_W-1:0] digit_to_sym(input logic [DIGIT_W-1:0] d);
    logic [SYM_W-1:0] dx;
    dx = SYM_W'(d);
    if (d < DIGIT_W'(DIGIT_UPPER_LO)) begin
      return dx + SYM_W'(ASCII_DIGIT_OFS);
    end else if (d < DIGIT_W'(DIGIT_LOWER_LO)) begin
      return dx + SYM_W'(ASCII_UPPER_OFS);
    end else begin
      return dx + SYM_W'(ASCII_LOWER_OFS);
    end
  endfunction

endpackage

[rtl/base62_number_to_digits_core.sv]
// Top level: 64-bit value in, base-62 ASCII characters out, most significant first.
`timescale 1ns / 1ps

// Usage:
//  - Slave stream (s_axis_*): one 64-bit unsigned value per request in tdata.
//  - Master stream (m_axis_*): one ASCII character per request, tdata[6:0] holds the
//    character, tdata[7] is zero, tlast marks the least significant digit of the run.
//  - A run has 1 to 11 characters with no leading zeros; zero gives the single '0'.
//  - The value enters a row of 11 digit cells one byte per cycle, top byte first;
//    each cell holds one base-62 digit and hands its carry to the next cell every
//    cycle; once the row has settled, the ST_LEAD state finds the leading digit.
//  - A new value is taken only once every character of the previous run is accepted.
//  - s_axis_tready is high only while no conversion is in flight.
//  - A stall on m_axis_tready holds the current character and tlast unchanged.
//  - Reset returns the block to idle with s_axis_tready high; nothing is kept
//    between values.

module base62_number_to_digits_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Slave stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [b62_pkg::NUM_W-1:0]      s_axis_tdata,   // [63:0] number
  // Master stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [b62_pkg::OUT_TD_W-1:0]   m_axis_tdata,   // [6:0] symbol, [7] zero pad
  output logic                           m_axis_tlast    // final_res
);
  import b62_pkg::*;

  b62_state_e state_q, state_d;
  logic [CNT_W-1:0]      cnt_q, cnt_d;
  logic [CELL_IDX_W-1:0] idx_q, idx_d;
  logic [NUM_W-1:0]      num_q, num_d;

  logic in_acc, clr;
  b62_link_t          links [CELL_N+1];
  logic [DIGIT_W-1:0] digits [CELL_N];
  logic [CELL_IDX_W-1:0] msd_idx;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign clr     = in_acc;

  // Feed the top byte into the least significant cell while chunks remain
  assign links[0].en    = (state_q == ST_CONV) && (cnt_q < CNT_W'(CHUNK_N));
  assign links[0].carry = num_q[NUM_W-1 -: CHUNK_W];

  // Row of digit cells, cell 0 is the least significant digit
  for (genvar g = 0; g < CELL_N; g++) begin : g_cell
    b62_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .clr_i   (clr),
      .link_i  (links[g]),
      .link_o  (links[g+1]),
      .digit_o (digits[g])
    );
  end

  // Find the most significant nonzero digit, default to digit 0
  always_comb begin
    msd_idx = '0;
    for (int i = 1; i < CELL_N; i++) begin
      if (digits[i] != '0) begin
        msd_idx = CELL_IDX_W'(i);
      end
    end
  end

  // Next state and stream outputs
  always_comb begin
    state_d       = state_q;
    cnt_d         = cnt_q;
    idx_d         = idx_q;
    num_d         = num_q;
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid) begin
          num_d   = s_axis_tdata;
          cnt_d   = '0;
          state_d = ST_CONV;
        end
      end
      ST_CONV: begin
        num_d = num_q << CHUNK_W;
        cnt_d = cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(CONV_CYCLES - 1)) begin
          state_d = ST_LEAD;
        end
      end
      ST_LEAD: begin
        idx_d   = msd_idx;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        m_axis_tvalid = 1'b1;
        if (m_axis_tready) begin
          if (idx_q == '0) begin
            state_d = ST_IDLE;
          end else begin
            idx_d = idx_q - CELL_IDX_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold the character under the emit index
  assign m_axis_tdata = OUT_TD_W'(digit_to_sym(digits[idx_q]));
  assign m_axis_tlast = (idx_q == '0);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  // Input shift register, payload only
  always_ff @(posedge clk_i) begin
    num_q <= num_d;
  end

endmodule

[rtl/b62_cell.sv]
// One base-62 digit cell: digit = (digit * 256 + carry_in) mod 62, carry out to the next cell.
`timescale 1ns / 1ps

module b62_cell (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         clr_i,
  input  b62_pkg::b62_link_t           link_i,
  output b62_pkg::b62_link_t           link_o,
  output logic [b62_pkg::DIGIT_W-1:0]  digit_o
);
  import b62_pkg::*;

  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [CHUNK_W-1:0] carry_q, carry_d;
  logic               en_q;

  logic [ACC_W-1:0]   acc;
  logic [PROD_W-1:0]  prod;
  logic [CHUNK_W-1:0] quot;
  logic [ACC_W-1:0]   rem_full;

  // Shift the chunk into this digit and split off the quotient by 62
  always_comb begin
    acc      = {digit_q, {CHUNK_W{1'b0}}} + ACC_W'(link_i.carry);
    prod     = PROD_W'(acc) * PROD_W'(RECIP_K);
    quot     = prod[RECIP_S +: CHUNK_W];
    // remainder = acc - 64*q + 2*q
    rem_full = acc - (ACC_W'(quot) << 6) + (ACC_W'(quot) << 1);
    digit_d  = link_i.en ? rem_full[DIGIT_W-1:0] : digit_q;
    carry_d  = link_i.en ? quot : '0;
  end

  // Hold the digit, pass the carry and the enable token onward
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      digit_q <= '0;
      carry_q <= '0;
      en_q    <= 1'b0;
    end else if (clr_i) begin
      digit_q <= '0;
      carry_q <= '0;
      en_q    <= 1'b0;
    end else begin
      digit_q <= digit_d;
      carry_q <= carry_d;
      en_q    <= link_i.en;
    end
  end

  assign link_o.en    = en_q;
  assign link_o.carry = carry_q;
  assign digit_o      = digit_q;

endmodule

[test/base62_number_to_digits_core_test.sv]
// Self-checking stream test of the base-62 digit converter.
`timescale 1ns / 1ps

module base62_number_to_digits_core_test;

  import b62_pkg::*;

  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned HOLD_OFF_LEN = 300;
  localparam int unsigned SETTLE_LEN   = 40;
  localparam int unsigned MAX_DIGITS   = 11;

  // One expected character of a run
  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             final_res;
  } digit_char_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [NUM_W-1:0]    s_axis_tdata  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OUT_TD_W-1:0] m_axis_tdata;
  logic                m_axis_tlast;

  digit_char_t expected_chars[$];
  int          error_count  = 0;
  int          idle_cycles  = 0;
  int          hold_off_len = 0;
  bit          tx_gaps_on   = 1'b1;
  bit          rx_gaps_on   = 1'b1;

  base62_number_to_digits_core DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // Free-running clock, 2 ns period
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // Map one digit value onto the 0-9, A-Z, a-z alphabet
  function automatic logic [SYM_W-1:0] digit_char(input int unsigned d);
    byte unsigned ch;
    if (d < 10) begin
      ch = 8'("0" + d);
    end else if (d < 36) begin
      ch = 8'("A" + (d - 10));
    end else begin
      ch = 8'("a" + (d - 36));
    end
    return ch[SYM_W-1:0];
  endfunction

  // Split a value into base-62 digits and queue its characters, top digit first
  function automatic void predict_digits(input logic [NUM_W-1:0] value);
    logic [NUM_W-1:0] rest;
    int unsigned      digit_vals[MAX_DIGITS];
    int               count;
    digit_char_t      ch;
    rest  = value;
    count = 0;
    do begin
      digit_vals[count] = int'(rest % 64'd62);
      rest              = rest / 64'd62;
      count++;
    end while (rest != 0 && count < MAX_DIGITS);
    for (int k = 0; k < count; k++) begin
      ch.symbol    = digit_char(digit_vals[count - 1 - k]);
      ch.final_res = (k == count - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  function automatic void note_error(input string msg);
    if (error_count < 10) begin
      $display("[%0t] mismatch: %s", $realtime, msg);
    end
    error_count++;
  endfunction

  // Offer one value after a random gap and hold it until the request is taken
  task automatic send_number(input logic [NUM_W-1:0] value);
    int gap;
    gap = tx_gaps_on ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= value;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_digits(value);
  endtask

  // Stop offering and wait until every queued character has come out
  task automatic wait_for_drain();
    s_axis_tvalid <= 1'b0;
    while (expected_chars.size() != 0) @(posedge clk_i);
  endtask

  // Single-digit alphabet edges, digit-count boundaries and the widest values
  task automatic test_digit_edges();
    logic [NUM_W-1:0] pw;
    send_number(64'd0);
    send_number(64'd9);
    send_number(64'd10);
    send_number(64'd35);
    send_number(64'd36);
    send_number(64'd61);
    pw = 64'd1;
    for (int k = 1; k <= 10; k++) begin
      pw = pw * 64'd62;
      if (k == 1 || k == 2 || k == 5 || k == 10) begin
        send_number(pw - 64'd1);
        send_number(pw);
      end
    end
    send_number({NUM_W{1'b1}});
    send_number({NUM_W{1'b1}} - 64'd1);
    send_number(64'h8000_0000_0000_0000);
    send_number(64'hAAAA_AAAA_AAAA_AAAA);
    send_number(64'h5555_5555_5555_5555);
    wait_for_drain();
  endtask

  // Random magnitudes so every run length shows up, idling changed per batch
  task automatic test_run_lengths();
    logic [NUM_W-1:0] raw;
    for (int batch = 0; batch < 4; batch++) begin
      tx_gaps_on = (batch == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      rx_gaps_on = (batch == 1) ? 1'b0 : 1'($urandom_range(0, 1));
      for (int n = 0; n < 15; n++) begin
        raw = {$urandom, $urandom};
        send_number(raw >> $urandom_range(0, NUM_W - 1));
      end
      // pause the sender until the block is empty
      wait_for_drain();
    end
    tx_gaps_on = 1'b1;
    rx_gaps_on = 1'b1;
  endtask

  // Full 64-bit random values, mostly eleven or ten digits long
  task automatic test_full_range();
    for (int n = 0; n < 40; n++) begin
      send_number({$urandom, $urandom});
    end
    wait_for_drain();
  endtask

  // Receiver holds off for a long stretch while values keep coming
  task automatic test_output_hold_off();
    hold_off_len = HOLD_OFF_LEN;
    for (int n = 0; n < 8; n++) begin
      send_number({$urandom, $urandom} >> $urandom_range(0, 40));
    end
    wait_for_drain();
  endtask

  // Receiver: random stall before each character, long hold-off on request
  initial begin
    int stall;
    forever begin
      if (hold_off_len > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_off_len) @(posedge clk_i);
        hold_off_len = 0;
      end
      stall = rx_gaps_on ? $urandom_range(0, 7) : 0;
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // Compare each accepted character with the oldest expected one
  always @(posedge clk_i) begin
    digit_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_chars.size() == 0) begin
        note_error($sformatf("unexpected character tdata %h tlast %b",
                             m_axis_tdata, m_axis_tlast));
      end else begin
        want = expected_chars.pop_front();
        if (m_axis_tdata !== {1'b0, want.symbol} || m_axis_tlast !== want.final_res) begin
          note_error($sformatf("expected tdata %h tlast %b, got tdata %h tlast %b",
                               {1'b0, want.symbol}, want.final_res,
                               m_axis_tdata, m_axis_tlast));
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves on either side for too long
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles + 1 >= IDLE_LIMIT) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  // Sequence the tests
  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_digit_edges();
    test_run_lengths();
    test_output_hold_off();
    test_full_range();
    wait_for_drain();
    repeat (SETTLE_LEN) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
